>>> src/selective_repeat_arq_window_unit_defines.svh
// assertion macros shared by the selective repeat window unit
`ifndef SELECTIVE_REPEAT_ARQ_WINDOW_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_WINDOW_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SRW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/srw_pkg.sv
// types, constants and codes of the selective repeat window unit
package srw_pkg;

    // link parameters (buffer slot count is a power of two)
    localparam int unsigned MAX_SEQUENCE    = 7;
    localparam int unsigned BUFFER_SLOTS    = 4;
    localparam int unsigned PAYLOAD_BYTES   = 256;
    localparam int unsigned MIN_FRAME_BYTES = 5;
    localparam int unsigned FRAME_OVERHEAD  = 7;
    localparam int unsigned MAX_RESULTS     = 20;

    // derived widths
    localparam int unsigned SEQ_MOD = MAX_SEQUENCE + 1;
    localparam int unsigned SEQ_W   = $clog2(SEQ_MOD);
    localparam int unsigned SLOT_W  = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int unsigned GUARD_W = $clog2(BUFFER_SLOTS + 1);
    localparam int unsigned CNT_W   = $clog2(MAX_RESULTS);
    localparam int unsigned BUF_W   = 3;

    // item field widths
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned SEQ_FW  = 3;
    localparam int unsigned TSLOT_W = 2;
    localparam int unsigned ACT_W   = 4;
    localparam int unsigned SLOT_FW = 2;

    // event codes
    typedef enum logic [MODE_W-1:0] {
        MODE_NET     = 3'd0,
        MODE_PHY     = 3'd1,
        MODE_RX      = 3'd2,
        MODE_ACK_TO  = 3'd3,
        MODE_DATA_TO = 3'd4
    } mode_t;

    // received frame kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NAK  = 2'd2
    } kind_t;

    // command codes
    typedef enum logic [ACT_W-1:0] {
        ACT_DATA     = 4'd0,
        ACT_NAK      = 4'd1,
        ACT_ACK      = 4'd2,
        ACT_DELIVER  = 4'd3,
        ACT_START_DT = 4'd4,
        ACT_STOP_DT  = 4'd5,
        ACT_START_AT = 4'd6,
        ACT_STOP_AT  = 4'd7,
        ACT_FETCH    = 4'd8,
        ACT_STORE    = 4'd9,
        ACT_STATUS   = 4'd10
    } action_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FETCH,
        ST_DATA,
        ST_START_DT,
        ST_NAK,
        ST_ACK,
        ST_STOP_AT,
        ST_START_AT,
        ST_STORE,
        ST_DELIVER,
        ST_DLV_AT,
        ST_STOP_DT,
        ST_STATUS
    } state_t;

    // source of the sequence number shown on a command
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_NTS,
        SRC_NR,
        SRC_RX_SEQ,
        SRC_EXP,
        SRC_OUA
    } seq_src_t;

    // load select of the retransmit sequence register
    typedef enum logic [1:0] {
        NR_HOLD,
        NR_NTS,
        NR_TIMEOUT,
        NR_ACK_NEXT
    } nr_sel_t;

    // input item
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               crc_ok;
        logic [LEN_W-1:0]   frame_length;
        logic [KIND_W-1:0]  frame_kind;
        logic [SEQ_FW-1:0]  frame_seq;
        logic [SEQ_FW-1:0]  ack_num;
        logic [TSLOT_W-1:0] timeout_slot;
    } srw_in_t;

    // result item
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [SEQ_FW-1:0]  out_seq;
        logic [SEQ_FW-1:0]  out_ack;
        logic [SLOT_FW-1:0] out_slot;
        logic [LEN_W-1:0]   deliver_length;
        logic               network_enable;
        logic               last;
    } srw_out_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             emit;
        logic [ACT_W-1:0] action;
        seq_src_t         seq_src;
        logic             piggy;
        logic             dlen_en;
        logic             status;
        logic             buf_inc;
        logic             buf_dec;
        logic             nts_inc;
        logic             oua_inc;
        logic             exp_inc;
        nr_sel_t          nr_sel;
        logic             lr_set;
        logic             lr_clr;
        logic             nak_set;
        logic             nak_clr;
        logic             arr_set;
        logic             guard_clr;
    } srw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              good_frame;
        logic [KIND_W-1:0] kind;
        logic              nak_allowed;
        logic              out_of_order;
        logic              nak_retx_go;
        logic              store_go;
        logic              deliver_go;
        logic              ack_scan_go;
        logic              out_free;
    } srw_stat_t;

endpackage

>>> src/selective_repeat_arq_window_unit.sv
// top level of the selective repeat window unit: sequencer and datapath
//
//  channel  direction  payload    handshake
//  s_       in         srw_in_t   s_valid / s_ready, one link event per item
//  m_       out        srw_out_t  m_valid / m_ready, one command per item
//
// an event is accepted in idle and decoded in dispatch, then one command is issued per state, and one per
// acked frame in the ack scan state, while the output is free, plus a state without a command for each
// window check that ends a phase (at most two); the whole run of up to twenty commands comes from one
// sequencer stepping through its states; the next event is taken once status has been issued
// reset is synchronous and active low; it restores the window state at once
// a stalled m_ready holds the sequencer on its current command
`include "selective_repeat_arq_window_unit_defines.svh"

module selective_repeat_arq_window_unit
    import srw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  srw_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output srw_out_t m_data
);

    srw_cmd_t  cmd;
    srw_stat_t stat;

    // command sequencer
    srw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // window state and result register
    srw_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

    // only the status command closes a run
    `SRW_ASSERT_SAME(a_last_is_status, aclk, aresetn, m_valid && m_data.last, m_data.action == ACT_STATUS, "last flag on a non-status command")
    // network enable rides only on the closing status
    `SRW_ASSERT_SAME(a_enable_on_last, aclk, aresetn, m_valid && m_data.network_enable, m_data.last, "network enable outside status")
    // a payload length only appears on a deliver command
    `SRW_ASSERT_SAME(a_len_on_deliver, aclk, aresetn, m_valid && (m_data.deliver_length != 0), m_data.action == ACT_DELIVER, "deliver length on another command")
    // one event at a time: an accepted item blocks the next one
    `SRW_ASSERT_NEXT(a_one_event, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while an event is in progress")

endmodule

>>> src/srw_ctrl.sv
// command sequencer of the selective repeat window unit
module srw_ctrl
    import srw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  srw_stat_t stat,
    output srw_cmd_t  cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands, one command per step while the output is free
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.mode)
                    MODE_NET:     state_next = ST_FETCH;
                    MODE_PHY: begin
                        cmd.lr_set = 1'b1;
                        state_next = ST_STATUS;
                    end
                    MODE_ACK_TO:  state_next = ST_ACK;
                    MODE_DATA_TO: begin
                        cmd.nr_sel = NR_TIMEOUT;
                        state_next = ST_DATA;
                    end
                    MODE_RX: begin
                        if (!stat.good_frame) begin
                            state_next = stat.nak_allowed ? ST_NAK : ST_STATUS;
                        end else if (stat.kind == KIND_DATA) begin
                            state_next = (stat.out_of_order && stat.nak_allowed) ?
                                         ST_NAK : ST_START_AT;
                        end else if (stat.kind == KIND_NAK && stat.nak_retx_go) begin
                            cmd.nr_sel = NR_ACK_NEXT;
                            state_next = ST_DATA;
                        end else begin
                            state_next = ST_STOP_DT;
                        end
                    end
                    default:      state_next = ST_STATUS;
                endcase
            end
            ST_FETCH: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.action  = ACT_FETCH;
                    cmd.seq_src = SRC_NTS;
                    cmd.buf_inc = 1'b1;
                    cmd.nr_sel  = NR_NTS;
                    cmd.nts_inc = 1'b1;
                    state_next  = ST_DATA;
                end
            end
            ST_DATA: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.action  = ACT_DATA;
                    cmd.seq_src = SRC_NR;
                    cmd.piggy   = 1'b1;
                    cmd.lr_clr  = 1'b1;
                    state_next  = ST_START_DT;
                end
            end
            ST_START_DT: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.action  = ACT_START_DT;
                    cmd.seq_src = SRC_NR;
                    state_next  = ST_STOP_AT;
                end
            end
            ST_NAK: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.action  = ACT_NAK;
                    cmd.piggy   = 1'b1;
                    cmd.nak_clr = 1'b1;
                    cmd.lr_clr  = 1'b1;
                    state_next  = ST_STOP_AT;
                end
            end
            ST_ACK: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.action = ACT_ACK;
                    cmd.piggy  = 1'b1;
                    cmd.lr_clr = 1'b1;
                    state_next = ST_STOP_AT;
                end
            end
            ST_STOP_AT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.action = ACT_STOP_AT;
                    // a good received frame goes on with its own handling
                    if (stat.mode == MODE_RX && stat.good_frame) begin
                        state_next = (stat.kind == KIND_DATA) ? ST_STORE : ST_STOP_DT;
                    end else begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_START_AT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.action = ACT_START_AT;
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (!stat.store_go) begin
                    state_next = ST_STOP_DT;
                end else if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.action    = ACT_STORE;
                    cmd.seq_src   = SRC_RX_SEQ;
                    cmd.arr_set   = 1'b1;
                    cmd.guard_clr = 1'b1;
                    state_next    = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!stat.deliver_go) begin
                    state_next = ST_STOP_DT;
                end else if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.action  = ACT_DELIVER;
                    cmd.seq_src = SRC_EXP;
                    cmd.dlen_en = 1'b1;
                    cmd.exp_inc = 1'b1;
                    cmd.nak_set = 1'b1;
                    state_next  = ST_DLV_AT;
                end
            end
            ST_DLV_AT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.action = ACT_START_AT;
                    state_next = ST_DELIVER;
                end
            end
            ST_STOP_DT: begin
                if (!stat.ack_scan_go) begin
                    state_next = ST_STATUS;
                end else if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.action  = ACT_STOP_DT;
                    cmd.seq_src = SRC_OUA;
                    cmd.buf_dec = 1'b1;
                    cmd.oua_inc = 1'b1;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.action = ACT_STATUS;
                    cmd.status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> src/srw_dp.sv
// window state, decision flags and result register of the selective repeat unit
module srw_dp
    import srw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  srw_in_t   s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output srw_out_t  m_data,
    input  srw_cmd_t  cmd,
    output srw_stat_t stat
);

    localparam logic [SEQ_W-1:0] RL_RESET = SEQ_W'(BUFFER_SLOTS % SEQ_MOD);

    // next sequence number modulo the sequence space
    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (32'(s) == MAX_SEQUENCE) ? '0 : s + 1'b1;
    endfunction

    // reduce a small value into the sequence space
    function automatic logic [SEQ_W-1:0] seq_reduce(input int unsigned v);
        int unsigned r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (r >= SEQ_MOD) r = r - SEQ_MOD;
        end
        return SEQ_W'(r);
    endfunction

    // b lies in the circular window [a, c)
    function automatic logic in_window(input int unsigned a, input int unsigned b,
                                       input int unsigned c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    srw_in_t            in_reg;
    logic [SEQ_W-1:0]   nts_reg, oua_reg, exp_reg, rl_reg, nr_reg;
    logic [BUF_W-1:0]   buf_reg;
    logic [BUFFER_SLOTS-1:0] arrived_reg;
    logic               lr_reg, nak_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic [CNT_W-1:0]   cnt_reg;
    srw_out_t           out_reg, out_next;
    logic               m_valid_reg;

    logic [SEQ_W-1:0]   rx_seq, rx_ack, ack_next, to_nr, piggy, seq_val;
    logic [SLOT_W-1:0]  rx_slot, exp_slot;
    logic [LEN_W-1:0]   dlen;
    logic               out_free, keep;
    int unsigned        to_sum;

    // decoded fields of the captured item
    always_comb begin
        rx_seq   = seq_reduce(32'(in_reg.frame_seq));
        rx_ack   = seq_reduce(32'(in_reg.ack_num));
        ack_next = seq_inc(rx_ack);
        to_sum   = 32'(in_reg.timeout_slot);
        if (!in_window(32'(oua_reg), 32'(in_reg.timeout_slot), 32'(nts_reg))) begin
            to_sum = to_sum + BUFFER_SLOTS;
        end
        to_nr    = seq_reduce(to_sum);
        piggy    = (exp_reg == '0) ? SEQ_W'(MAX_SEQUENCE) : exp_reg - 1'b1;
        rx_slot  = SLOT_W'(rx_seq % BUFFER_SLOTS);
        exp_slot = SLOT_W'(exp_reg % BUFFER_SLOTS);
    end

    // payload length, clipped to the buffer size
    always_comb begin
        dlen = '0;
        if (32'(in_reg.frame_length) > FRAME_OVERHEAD) begin
            dlen = in_reg.frame_length - LEN_W'(FRAME_OVERHEAD);
        end
        if (32'(dlen) > PAYLOAD_BYTES) begin
            dlen = LEN_W'(PAYLOAD_BYTES);
        end
    end

    // status flags for the sequencer
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        stat.mode         = in_reg.mode;
        stat.good_frame   = (32'(in_reg.frame_length) >= MIN_FRAME_BYTES) && in_reg.crc_ok;
        stat.kind         = in_reg.frame_kind;
        stat.nak_allowed  = nak_reg;
        stat.out_of_order = (rx_seq != exp_reg);
        stat.nak_retx_go  = in_window(32'(oua_reg), 32'(ack_next), 32'(nts_reg));
        stat.store_go     = in_window(32'(exp_reg), 32'(rx_seq), 32'(rl_reg)) &&
                            !arrived_reg[rx_slot];
        stat.deliver_go   = (guard_reg < GUARD_W'(BUFFER_SLOTS)) && arrived_reg[exp_slot];
        stat.ack_scan_go  = in_window(32'(oua_reg), 32'(rx_ack), 32'(nts_reg));
        stat.out_free     = out_free;
    end

    // command word formed from the selected sources
    always_comb begin
        case (cmd.seq_src)
            SRC_NTS:    seq_val = nts_reg;
            SRC_NR:     seq_val = nr_reg;
            SRC_RX_SEQ: seq_val = rx_seq;
            SRC_EXP:    seq_val = exp_reg;
            SRC_OUA:    seq_val = oua_reg;
            default:    seq_val = '0;
        endcase
        out_next.action         = cmd.action;
        out_next.out_seq        = SEQ_FW'(seq_val);
        out_next.out_ack        = cmd.piggy ? SEQ_FW'(piggy) : '0;
        out_next.out_slot       = SLOT_FW'(seq_val % BUFFER_SLOTS);
        out_next.deliver_length = cmd.dlen_en ? dlen : '0;
        out_next.network_enable = cmd.status && (32'(buf_reg) < BUFFER_SLOTS) && lr_reg;
        out_next.last           = cmd.status;
        // commands past the run limit are dropped, status always goes out
        keep = cmd.status || (cnt_reg < CNT_W'(MAX_RESULTS - 1));
    end

    // window and flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nts_reg     <= '0;
            oua_reg     <= '0;
            exp_reg     <= '0;
            rl_reg      <= RL_RESET;
            buf_reg     <= '0;
            arrived_reg <= '0;
            lr_reg      <= 1'b0;
            nak_reg     <= 1'b1;
            guard_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.nts_inc) nts_reg <= seq_inc(nts_reg);
            if (cmd.oua_inc) oua_reg <= seq_inc(oua_reg);
            if (cmd.buf_inc) buf_reg <= buf_reg + 1'b1;
            if (cmd.buf_dec) buf_reg <= buf_reg - 1'b1;
            if (cmd.lr_set)  lr_reg  <= 1'b1;
            if (cmd.lr_clr)  lr_reg  <= 1'b0;
            if (cmd.nak_set) nak_reg <= 1'b1;
            if (cmd.nak_clr) nak_reg <= 1'b0;
            if (cmd.arr_set) arrived_reg[rx_slot] <= 1'b1;
            if (cmd.guard_clr) guard_reg <= '0;
            // in-order delivery slides the receive window
            if (cmd.exp_inc) begin
                arrived_reg[exp_slot] <= 1'b0;
                exp_reg   <= seq_inc(exp_reg);
                rl_reg    <= seq_inc(rl_reg);
                guard_reg <= guard_reg + 1'b1;
            end
            // run length count
            if (cmd.capture) begin
                cnt_reg <= '0;
            end else if (cmd.emit && !cmd.status && keep) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            // result valid
            if (cmd.emit && keep) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // captured item, retransmit sequence and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) in_reg <= s_data;
        case (cmd.nr_sel)
            NR_NTS:      nr_reg <= nts_reg;
            NR_TIMEOUT:  nr_reg <= to_nr;
            NR_ACK_NEXT: nr_reg <= ack_next;
            default:     nr_reg <= nr_reg;
        endcase
        if (cmd.emit && keep) out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> tb/tb.sv
// testbench of the selective repeat window unit: event driver, window model and command checker
`timescale 1ns / 100ps

import srw_pkg::*;

// window model: predicts the command run of every accepted event item and checks results
class window_scoreboard;
    typedef logic [SEQ_W-1:0]   seq_t;
    typedef logic [SLOT_FW-1:0] slot_t;
    typedef logic [LEN_W-1:0]   len_t;

    // sender and receiver window state
    seq_t             next_out;
    seq_t             ack_base;
    seq_t             rx_expected;
    seq_t             rx_limit;
    logic [BUF_W-1:0] buffered;
    bit               arrived [BUFFER_SLOTS];
    bit               line_free;
    bit               nak_open;

    // commands still to come, oldest first
    srw_out_t expected_cmds [$];
    int       run_len;
    int       errors;
    int       reports;
    int       commands;
    int       delivers;
    int       mode_hits [8];

    function new();
        next_out    = '0;
        ack_base    = '0;
        rx_expected = '0;
        rx_limit    = seq_t'(BUFFER_SLOTS % SEQ_MOD);
        buffered    = '0;
        foreach (arrived[i]) arrived[i] = 1'b0;
        line_free   = 1'b0;
        nak_open    = 1'b1;
    endfunction

    function seq_t seq_after(seq_t s);
        return seq_t'((s + 1) % SEQ_MOD);
    endfunction

    function slot_t slot_of(seq_t s);
        return slot_t'(s % BUFFER_SLOTS);
    endfunction

    // circular window test a <= b < c
    function bit between(seq_t a, seq_t b, seq_t c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    function seq_t ack_field();
        return seq_t'((rx_expected + MAX_SEQUENCE) % SEQ_MOD);
    endfunction

    // queue one command, dropping anything past the run limit except status
    function void add_cmd(action_t act, seq_t seq, seq_t ack, slot_t slot, len_t len,
                          bit en, bit fin);
        srw_out_t c;
        if (!fin && run_len >= MAX_RESULTS - 1) return;
        c.action         = act;
        c.out_seq        = seq;
        c.out_ack        = ack;
        c.out_slot       = slot;
        c.deliver_length = len;
        c.network_enable = en;
        c.last           = fin;
        expected_cmds.push_back(c);
        run_len++;
    endfunction

    // frame send with its timer commands
    function void transmit(action_t kind, seq_t nr);
        if (kind == ACT_DATA) begin
            add_cmd(ACT_DATA, nr, ack_field(), slot_of(nr), '0, 1'b0, 1'b0);
            add_cmd(ACT_START_DT, nr, '0, slot_of(nr), '0, 1'b0, 1'b0);
        end else begin
            if (kind == ACT_NAK) nak_open = 1'b0;
            add_cmd(kind, '0, ack_field(), '0, '0, 1'b0, 1'b0);
        end
        line_free = 1'b0;
        add_cmd(ACT_STOP_AT, '0, '0, '0, '0, 1'b0, 1'b0);
    endfunction

    // received frame: nak, store and deliver, retransmit, then cumulative ack
    function void take_frame(srw_in_t ev);
        seq_t rseq;
        seq_t rack;
        seq_t nr;
        len_t dlen;
        int   g;
        rseq = seq_t'(ev.frame_seq % SEQ_MOD);
        rack = seq_t'(ev.ack_num % SEQ_MOD);
        if (ev.frame_length < MIN_FRAME_BYTES || !ev.crc_ok) begin
            if (nak_open) transmit(ACT_NAK, '0);
            return;
        end
        if (ev.frame_kind == KIND_DATA) begin
            if (rseq != rx_expected && nak_open) transmit(ACT_NAK, '0);
            else add_cmd(ACT_START_AT, '0, '0, '0, '0, 1'b0, 1'b0);
            if (between(rx_expected, rseq, rx_limit) && !arrived[slot_of(rseq)]) begin
                dlen = '0;
                if (ev.frame_length > FRAME_OVERHEAD)
                    dlen = len_t'(ev.frame_length - FRAME_OVERHEAD);
                if (dlen > PAYLOAD_BYTES) dlen = len_t'(PAYLOAD_BYTES);
                arrived[slot_of(rseq)] = 1'b1;
                add_cmd(ACT_STORE, rseq, '0, slot_of(rseq), '0, 1'b0, 1'b0);
                for (g = 0; g < BUFFER_SLOTS && arrived[slot_of(rx_expected)]; g++) begin
                    add_cmd(ACT_DELIVER, rx_expected, '0, slot_of(rx_expected), dlen,
                            1'b0, 1'b0);
                    delivers++;
                    nak_open = 1'b1;
                    arrived[slot_of(rx_expected)] = 1'b0;
                    rx_expected = seq_after(rx_expected);
                    rx_limit    = seq_after(rx_limit);
                    add_cmd(ACT_START_AT, '0, '0, '0, '0, 1'b0, 1'b0);
                end
            end
        end
        if (ev.frame_kind == KIND_NAK) begin
            nr = seq_after(rack);
            if (between(ack_base, nr, next_out)) transmit(ACT_DATA, nr);
        end
        while (between(ack_base, rack, next_out)) begin
            buffered = buffered - 1'b1;
            add_cmd(ACT_STOP_DT, ack_base, '0, slot_of(ack_base), '0, 1'b0, 1'b0);
            ack_base = seq_after(ack_base);
        end
    endfunction

    // accepted event item: queue its whole command run
    function void note_event(srw_in_t ev);
        seq_t nr;
        run_len = 0;
        mode_hits[ev.mode]++;
        case (ev.mode)
            MODE_NET: begin
                buffered = buffered + 1'b1;
                add_cmd(ACT_FETCH, next_out, '0, slot_of(next_out), '0, 1'b0, 1'b0);
                transmit(ACT_DATA, next_out);
                next_out = seq_after(next_out);
            end
            MODE_PHY: line_free = 1'b1;
            MODE_RX: take_frame(ev);
            MODE_ACK_TO: transmit(ACT_ACK, '0);
            MODE_DATA_TO: begin
                nr = seq_t'(ev.timeout_slot);
                // slot outside the sender window refers to the upper half
                if (!between(ack_base, nr, next_out))
                    nr = seq_t'((nr + BUFFER_SLOTS) % SEQ_MOD);
                transmit(ACT_DATA, nr);
            end
            default: ;
        endcase
        add_cmd(ACT_STATUS, '0, '0, '0, '0, buffered < BUFFER_SLOTS && line_free, 1'b1);
    endfunction

    function void report(string msg);
        errors++;
        if (reports < 40) begin
            reports++;
            $display("time %0d ns: %s", $time, msg);
        end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report($sformatf("%s mismatch, expected %0d, actual %0d", name, want, got));
    endfunction

    // accepted result item against the oldest expectation
    function void check_command(srw_out_t got);
        srw_out_t want;
        commands++;
        if (expected_cmds.size() == 0) begin
            report($sformatf("unexpected command, expected none, actual action %0d",
                             got.action));
            return;
        end
        want = expected_cmds.pop_front();
        compare_field("action", 16'(want.action), 16'(got.action));
        compare_field("out_seq", 16'(want.out_seq), 16'(got.out_seq));
        compare_field("out_ack", 16'(want.out_ack), 16'(got.out_ack));
        compare_field("out_slot", 16'(want.out_slot), 16'(got.out_slot));
        compare_field("deliver_length", 16'(want.deliver_length), 16'(got.deliver_length));
        compare_field("network_enable", 16'(want.network_enable), 16'(got.network_enable));
        compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
endclass

module tb;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int                RANDOM_EVENTS = 500;
    localparam int                CALM_FROM     = 440;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    srw_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    srw_out_t m_data;

    window_scoreboard board = new();
    bit               calm  = 1'b0;

    selective_repeat_arq_window_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_command(m_data);
    end

    // result side stalls in bursts
    initial begin
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    function automatic srw_in_t make_event(logic [MODE_W-1:0] mode, logic crc,
                                           logic [LEN_W-1:0] len, logic [KIND_W-1:0] kind,
                                           logic [SEQ_FW-1:0] seq, logic [SEQ_FW-1:0] ack,
                                           logic [TSLOT_W-1:0] slot);
        srw_in_t ev;
        ev.mode         = mode;
        ev.crc_ok       = crc;
        ev.frame_length = len;
        ev.frame_kind   = kind;
        ev.frame_seq    = seq;
        ev.ack_num      = ack;
        ev.timeout_slot = slot;
        return ev;
    endfunction

    // mostly well-formed link traffic that follows the current windows, some noise
    function automatic srw_in_t pick_event();
        srw_in_t     ev;
        int unsigned pick;
        int unsigned outstanding;
        ev = srw_in_t'($urandom);
        outstanding = 32'(SEQ_W'(board.next_out - board.ack_base));
        ev.crc_ok = 1'b1;
        ev.frame_length = LEN_W'($urandom_range(MIN_FRAME_BYTES, 263));
        if (outstanding > 0 && $urandom_range(0, 3) != 0)
            ev.ack_num = SEQ_FW'(board.ack_base + $urandom_range(0, outstanding - 1));
        else
            ev.ack_num = SEQ_FW'(board.ack_base + MAX_SEQUENCE);
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            ev.mode = (outstanding < BUFFER_SLOTS || pick < 2) ? MODE_NET : MODE_PHY;
        end else if (pick < 32) begin
            ev.mode = MODE_PHY;
        end else if (pick < 62) begin
            // in-order data half of the time, else ahead of or past the window
            ev.mode = MODE_RX;
            ev.frame_kind = KIND_DATA;
            ev.frame_seq = SEQ_FW'(board.rx_expected +
                                   ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4)));
        end else if (pick < 74) begin
            ev.mode = MODE_RX;
            ev.frame_kind = KIND_ACK;
        end else if (pick < 82) begin
            ev.mode = MODE_RX;
            ev.frame_kind = KIND_NAK;
            if (outstanding > 0)
                ev.ack_num = SEQ_FW'(board.ack_base + $urandom_range(0, outstanding - 1)
                                     + MAX_SEQUENCE);
        end else if (pick < 87) begin
            ev.mode = MODE_ACK_TO;
        end else if (pick < 92) begin
            ev.mode = MODE_DATA_TO;
        end else if (pick < 96) begin
            // corrupted or truncated frame
            ev.mode = MODE_RX;
            if ($urandom_range(0, 1)) ev.crc_ok = 1'b0;
            else ev.frame_length = LEN_W'($urandom_range(0, MIN_FRAME_BYTES - 1));
        end else begin
            // anything: unknown modes and kinds, oversize lengths
            ev = srw_in_t'($urandom);
        end
        return ev;
    endfunction

    // present one event item and wait for its acceptance
    task automatic post_event(input srw_in_t ev);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        board.note_event(ev);
    endtask

    // stimulus and end of run
    initial begin
        int n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unknown modes give status only
        for (n = MODE_DATA_TO + 1; n < (1 << MODE_W); n++)
            post_event(make_event(MODE_W'(n), 1'b1, 9'd100, KIND_DATA, 3'd0, 3'd7, 2'd0));
        post_event(make_event(MODE_PHY, 1'b0, 9'd0, KIND_DATA, 3'd0, 3'd0, 2'd0));
        post_event(make_event(MODE_NET, 1'b0, 9'd0, KIND_DATA, 3'd0, 3'd0, 2'd0));
        post_event(make_event(MODE_NET, 1'b1, 9'd511, KIND_UNKNOWN, 3'd7, 3'd7, 2'd3));
        // ack of frame zero, then nak asking for frame one again
        post_event(make_event(MODE_RX, 1'b1, 9'd5, KIND_ACK, 3'd0, 3'd0, 2'd0));
        post_event(make_event(MODE_RX, 1'b1, 9'd20, KIND_NAK, 3'd0, 3'd0, 2'd0));
        // data timeout inside and outside the sender window
        post_event(make_event(MODE_DATA_TO, 1'b0, 9'd0, KIND_DATA, 3'd0, 3'd0, 2'd1));
        post_event(make_event(MODE_DATA_TO, 1'b0, 9'd0, KIND_DATA, 3'd0, 3'd0, 2'd3));
        post_event(make_event(MODE_ACK_TO, 1'b0, 9'd0, KIND_DATA, 3'd0, 3'd0, 2'd0));
        // short frame naks, bad crc right after finds the nak already spent
        post_event(make_event(MODE_RX, 1'b1, 9'd0, KIND_DATA, 3'd0, 3'd7, 2'd0));
        post_event(make_event(MODE_RX, 1'b0, 9'd263, KIND_DATA, 3'd0, 3'd7, 2'd0));
        // full payload, then out of order pair with oversize length
        post_event(make_event(MODE_RX, 1'b1, 9'd263, KIND_DATA, 3'd0, 3'd7, 2'd0));
        post_event(make_event(MODE_RX, 1'b1, 9'd7, KIND_DATA, 3'd2, 3'd7, 2'd0));
        post_event(make_event(MODE_RX, 1'b1, 9'd511, KIND_DATA, 3'd1, 3'd7, 2'd0));
        // unknown kind still carries an ack
        post_event(make_event(MODE_RX, 1'b1, 9'd8, KIND_UNKNOWN, 3'd7, 3'd1, 2'd0));
        // enough packets to wrap the buffer count
        for (n = 0; n < 2 * BUFFER_SLOTS; n++)
            post_event(make_event(MODE_NET, 1'b0, 9'd0, KIND_DATA, 3'd0, 3'd0, 2'd0));

        for (n = 0; n < RANDOM_EVENTS; n++) begin
            if (n == CALM_FROM) calm = 1'b1;
            post_event(pick_event());
        end
        s_valid <= 1'b0;

        while (board.expected_cmds.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("events: %0d net, %0d phy, %0d frame, %0d ack timeout, %0d data timeout, %0d unknown",
                 board.mode_hits[MODE_NET], board.mode_hits[MODE_PHY],
                 board.mode_hits[MODE_RX], board.mode_hits[MODE_ACK_TO],
                 board.mode_hits[MODE_DATA_TO],
                 board.mode_hits[5] + board.mode_hits[6] + board.mode_hits[7]);
        $display("commands checked: %0d, deliveries among them: %0d, mismatches: %0d",
                 board.commands, board.delivers, board.errors);
        if (board.errors == 0) begin
            $display("selective_repeat_arq_window_unit test passed");
        end else begin
            $display("selective_repeat_arq_window_unit test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #15_000_000;
        $display("timeout waiting for the block");
        $display("selective_repeat_arq_window_unit test failed");
        $finish;
    end
endmodule
